>>> sv/salc_pkg.sv
// Package for the set-associative LRU cache model: request and response words,
// configuration register indexes, reset values and default geometry.
// No dependencies.
package salc_pkg;

  localparam int unsigned MAX_SET_BITS = 8;
  localparam int unsigned MAX_WAYS     = 8;
  localparam int unsigned STAMP_BITS   = 32;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TOTAL_W = 32;

  localparam int unsigned SET_BITS_W   = 4;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned BLOCK_BITS_W = 6;
  localparam int unsigned CFG_DATA_W   = 6;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;

  localparam logic [1:0] REQ_MODIFY = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
  } cache_req_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [TOTAL_W-1:0] hits_total;
    logic [TOTAL_W-1:0] misses_total;
    logic [TOTAL_W-1:0] evictions_total;
  } cache_rsp_t;

endpackage

>>> sv/set_assoc_lru_cache_sim.sv
// An accepted word is looked up in ST_LOOKUP and its result word is registered
// on commit, which an output stall holds off. A new word is taken only after the
// last has committed; the set row is read from the single-port line memory on
// accept and written back on commit. Reset clears counters and resets config at
// once, then sweeps the line memory one set per cycle while holding off requests.
// Depends on salc_pkg.
module set_assoc_lru_cache_sim #(
  parameter int unsigned MaxSetBits = salc_pkg::MAX_SET_BITS,
  parameter int unsigned MaxWays    = salc_pkg::MAX_WAYS,
  parameter int unsigned StampBits  = salc_pkg::STAMP_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  salc_pkg::cache_req_t                  in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output salc_pkg::cache_rsp_t                  out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import salc_pkg::*;

  localparam int unsigned SetW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned NumSets = 2 ** MaxSetBits;
  localparam int unsigned WayW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned LineW   = 1 + ADDR_W + StampBits;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  typedef logic [MaxWays-1:0][LineW-1:0] row_t;

  state_e                  state_q, state_d;
  logic [SetW-1:0]         clr_cnt_q, clr_cnt_d;
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [StampBits-1:0]    stamp_q, stamp_d;
  logic [TOTAL_W-1:0]      hits_q, hits_d;
  logic [TOTAL_W-1:0]      misses_q, misses_d;
  logic [TOTAL_W-1:0]      evicts_q, evicts_d;
  logic                    out_valid_q, out_valid_d;
  cache_rsp_t              out_data_q, out_data_d;

  logic [ADDR_W-1:0]       tag_q, tag_d;
  logic [SetW-1:0]         set_q, set_d;
  logic                    modify_q;

  row_t                    mem_q [NumSets];
  row_t                    row_q;
  row_t                    row_d;
  logic                    mem_we;
  logic [SetW-1:0]         mem_waddr;
  row_t                    mem_wdata;

  logic                    accept;
  logic                    commit;
  logic [SET_BITS_W-1:0]   sb;
  logic [6:0]              sh;
  logic [ADDR_W-1:0]       blk_addr;
  logic [SetW-1:0]         set_mask;
  logic [4:0]              nw;

  logic                    hit_found;
  logic [WayW-1:0]         hit_way;
  logic                    empty_found;
  logic [WayW-1:0]         empty_way;
  logic [WayW-1:0]         lru_way;
  logic [StampBits-1:0]    min_stamp;
  logic [WayW-1:0]         victim;
  logic                    evict;
  logic [StampBits-1:0]    line_stamp;
  logic [1:0]              hit_inc;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                 input logic [1:0] inc);
    logic [TOTAL_W:0] s;
    s = {1'b0, v} + (TOTAL_W+1)'(inc);
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign commit     = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    sb       = (set_bits_q > SET_BITS_W'(MaxSetBits)) ? SET_BITS_W'(MaxSetBits) : set_bits_q;
    sh       = 7'(sb) + 7'(block_bits_q);
    blk_addr = in_data_i.address >> block_bits_q;
    for (int i = 0; i < SetW; i++) begin
      set_mask[i] = (i < 32'(sb));
    end
    set_d = blk_addr[SetW-1:0] & set_mask;
    tag_d = sh[6] ? '0 : (in_data_i.address >> sh[5:0]);
  end

  always_comb begin
    if (ways_q == '0) begin
      nw = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MaxWays)) begin
      nw = 5'(MaxWays);
    end else begin
      nw = {1'b0, ways_q};
    end
  end

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    lru_way     = '0;
    min_stamp   = row_q[0][StampBits-1:0];
    for (int w = 0; w < MaxWays; w++) begin
      if (5'(w) < nw) begin
        if (!hit_found && row_q[w][LineW-1] && (row_q[w][LineW-2 -: ADDR_W] == tag_q)) begin
          hit_found = 1'b1;
          hit_way   = WayW'(w);
        end
        if (!empty_found && !row_q[w][LineW-1]) begin
          empty_found = 1'b1;
          empty_way   = WayW'(w);
        end
        if (row_q[w][StampBits-1:0] < min_stamp) begin
          min_stamp = row_q[w][StampBits-1:0];
          lru_way   = WayW'(w);
        end
      end
    end
    evict      = !hit_found && !empty_found;
    victim     = hit_found ? hit_way : (empty_found ? empty_way : lru_way);
    line_stamp = stamp_q + StampBits'(modify_q);
    row_d          = row_q;
    row_d[victim]  = {1'b1, tag_q, line_stamp};
  end

  always_comb begin
    hit_inc  = 2'(hit_found) + 2'(modify_q);
    stamp_d  = stamp_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (commit) begin
      stamp_d  = stamp_q + StampBits'(1) + StampBits'(modify_q);
      hits_d   = sat_add(hits_q, hit_inc);
      misses_d = sat_add(misses_q, {1'b0, !hit_found});
      evicts_d = sat_add(evicts_q, {1'b0, evict});
    end
    out_data_d                 = out_data_q;
    out_data_d.hit             = hit_found;
    out_data_d.evicted         = evict;
    out_data_d.hits_total      = hits_d;
    out_data_d.misses_total    = misses_d;
    out_data_d.evictions_total = evicts_d;
    out_valid_d = out_valid_q && out_stall_i;
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SetW'(1);
        if (clr_cnt_q == SetW'(NumSets - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign mem_we    = (state_q == ST_CLEAR) || commit;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : row_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      row_q <= mem_q[set_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q    <= tag_d;
      set_q    <= set_d;
      modify_q <= (in_data_i.req_type == REQ_MODIFY);
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      set_bits_q   <= SET_BITS_RST;
      ways_q       <= WAYS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      stamp_q      <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      stamp_q     <= stamp_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SET_BITS_W-1:0];
          CFG_WAYS:       ways_q       <= cfg_data_i[WAYS_W-1:0];
          CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BLOCK_BITS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/salc_chk.sv
// Port-level checks for set_assoc_lru_cache_sim, bound into every instance of it.
// Depends on salc_pkg.
module salc_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input salc_pkg::cache_rsp_t            out_data_o
);
  import salc_pkg::*;

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while lookup pending");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted))
    else $error("hit flagged together with eviction");

  a_evict_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |-> out_data_o.evictions_total != '0)
    else $error("eviction without eviction count");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.misses_total != '0)
    else $error("miss without miss count");

endmodule

bind set_assoc_lru_cache_sim salc_chk u_salc_chk (.*);

>>> tb/tb_set_assoc_lru_cache_sim.sv
// Testbench for set_assoc_lru_cache_sim: a scoreboard with its own LRU cache predictor
// checks every result word (hit, eviction, running totals) across many cache geometries.
// Depends on salc_pkg and the cache RTL.
module tb_set_assoc_lru_cache_sim;
  import salc_pkg::*;

  localparam int unsigned NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_ODD   = 2'd3;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned FIXED_PHASES    = 8;
  localparam int unsigned WORDS_PER_PHASE = 175;
  localparam int unsigned POOL_MAX        = 12;
  localparam int unsigned OPENING_WORDS   = 16;

  class lru_scoreboard;
    logic [SET_BITS_W-1:0]   set_bits_r;
    logic [WAYS_W-1:0]       ways_r;
    logic [BLOCK_BITS_W-1:0] block_bits_r;
    bit                      line_valid [NUM_LINES];
    logic [ADDR_W-1:0]       line_tag   [NUM_LINES];
    logic [STAMP_BITS-1:0]   line_stamp [NUM_LINES];
    logic [STAMP_BITS-1:0]   stamp_next;
    logic [TOTAL_W-1:0]      hits;
    logic [TOTAL_W-1:0]      misses;
    logic [TOTAL_W-1:0]      evictions;
    cache_rsp_t              rsp_due [$];
    int unsigned             errors;
    int unsigned             hits_seen;
    int unsigned             evicts_seen;

    function new();
      set_bits_r   = SET_BITS_RST;
      ways_r       = WAYS_RST;
      block_bits_r = BLOCK_BITS_RST;
      stamp_next   = '0;
      hits         = '0;
      misses       = '0;
      evictions    = '0;
      errors       = 0;
      hits_seen    = 0;
      evicts_seen  = 0;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SET_BITS:   set_bits_r   = data[SET_BITS_W-1:0];
        CFG_WAYS:       ways_r       = data[WAYS_W-1:0];
        CFG_BLOCK_BITS: block_bits_r = data[BLOCK_BITS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit touch(logic [ADDR_W-1:0] addr, output bit evict);
      int unsigned       sb, nw, bb, sh, base, lru, victim, w;
      int                free_way;
      logic [ADDR_W-1:0] tag;
      sb = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
      nw = (ways_r == 0) ? 1 : ((ways_r > MAX_WAYS) ? MAX_WAYS : ways_r);
      bb = block_bits_r;
      sh = sb + bb;
      tag = (sh >= ADDR_W) ? '0 : (addr >> sh);
      base = int'((addr >> bb) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
      free_way = -1;
      lru = 0;
      evict = 1'b0;
      for (w = 0; w < nw; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          line_stamp[base + w] = stamp_next;
          stamp_next++;
          hits = sat_inc(hits);
          return 1'b1;
        end
        if (!line_valid[base + w] && free_way < 0) free_way = int'(w);
        if (line_stamp[base + w] < line_stamp[base + lru]) lru = w;
      end
      if (free_way >= 0) begin
        victim = free_way;
      end else begin
        victim = lru;
        evict = 1'b1;
        evictions = sat_inc(evictions);
      end
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = stamp_next;
      stamp_next++;
      misses = sat_inc(misses);
      return 1'b0;
    endfunction

    function void note_access(cache_req_t req);
      bit         ev_first, ev_second, was_hit;
      cache_rsp_t want;
      was_hit = touch(req.address, ev_first);
      if (req.req_type == REQ_MODIFY) void'(touch(req.address, ev_second));
      want.hit             = was_hit;
      want.evicted         = ev_first;
      want.hits_total      = hits;
      want.misses_total    = misses;
      want.evictions_total = evictions;
      rsp_due.push_back(want);
    endfunction

    function void compare(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cache_rsp_t got);
      cache_rsp_t want;
      if (rsp_due.size() == 0) begin
        $error("result word with no access pending");
        errors++;
        return;
      end
      want = rsp_due.pop_front();
      compare("hit", TOTAL_W'(want.hit), TOTAL_W'(got.hit));
      compare("evicted", TOTAL_W'(want.evicted), TOTAL_W'(got.evicted));
      compare("hits_total", want.hits_total, got.hits_total);
      compare("misses_total", want.misses_total, got.misses_total);
      compare("evictions_total", want.evictions_total, got.evictions_total);
      if (want.hit) hits_seen++;
      if (want.evicted) evicts_seen++;
    endfunction

    function int unsigned pending();
      return rsp_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cache_req_t            in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cache_rsp_t            out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       words_sent = 0;
  logic [ADDR_W-1:0] tag_pool [POOL_MAX];
  int unsigned       pool_n = 1;
  lru_scoreboard     cache_sb;

  logic [CFG_DATA_W-1:0] geo_sets   [FIXED_PHASES] = '{0, 8, 15, 2, 3, 8, 1, 6};
  logic [CFG_DATA_W-1:0] geo_ways   [FIXED_PHASES] = '{1, 8, 15, 4, 0, 8, 2, 3};
  logic [CFG_DATA_W-1:0] geo_blocks [FIXED_PHASES] = '{0, 32, 63, 6, 5, 56, 60, 0};

  logic [1:0] opening_kind [OPENING_WORDS] = '{
    REQ_LOAD, REQ_LOAD, REQ_STORE, REQ_MODIFY, REQ_LOAD, REQ_ODD, REQ_LOAD, REQ_STORE,
    REQ_MODIFY, REQ_MODIFY, REQ_MODIFY, REQ_LOAD, REQ_STORE, REQ_LOAD, REQ_LOAD, REQ_ODD};
  logic [ADDR_W-1:0] opening_addr [OPENING_WORDS] = '{
    64'h0, 64'hF, 64'h0, 64'h100, 64'h0, 64'h100, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF0F, 64'h20, 64'h2F,
    64'h8000_0000_0000_0000, 64'h1234_5678_9ABC_DEF0, 64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

  set_assoc_lru_cache_sim dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) cache_sb.check_result(out_data);
      if (in_valid == 1'b1 && in_stall === 1'b0) cache_sb.note_access(in_data);
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  task automatic send_word(input cache_req_t word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cache_sb.pending() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cache_sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Mostly addresses built from a small tag pool and a few sets, so hits and
  // evictions are common; the rest is fully random noise.
  function automatic cache_req_t random_access();
    cache_req_t        word;
    int unsigned       sbits, bbits;
    logic [ADDR_W-1:0] set_idx, offs, tag;
    word.req_type = 2'($urandom_range(0, 3));
    sbits = (cache_sb.set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : cache_sb.set_bits_r;
    bbits = cache_sb.block_bits_r;
    if ($urandom_range(0, 99) < 12) begin
      word.address = {$urandom, $urandom};
    end else begin
      tag = tag_pool[$urandom_range(0, pool_n - 1)];
      set_idx = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 3)) : 64'($urandom);
      set_idx &= (64'd1 << sbits) - 64'd1;
      offs = {$urandom, $urandom} & ((64'd1 << bbits) - 64'd1);
      word.address = ((sbits + bbits >= ADDR_W) ? '0 : (tag << (sbits + bbits)))
                   | (set_idx << bbits) | offs;
    end
    return word;
  endfunction

  initial begin
    cache_req_t  word;
    int unsigned nw;
    cache_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OPENING_WORDS; i++) begin
      word.req_type = opening_kind[i];
      word.address  = opening_addr[i];
      send_word(word);
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        write_cfg(CFG_SET_BITS, geo_sets[ph]);
        write_cfg(CFG_WAYS, geo_ways[ph]);
        write_cfg(CFG_BLOCK_BITS, geo_blocks[ph]);
      end else begin
        write_cfg(CFG_SET_BITS, CFG_DATA_W'($urandom_range(0, 63)));
        write_cfg(CFG_WAYS, CFG_DATA_W'($urandom_range(0, 63)));
        write_cfg(CFG_BLOCK_BITS, CFG_DATA_W'($urandom_range(0, 63)));
      end
      if (ph == 4) write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 63)));
      cfg_we <= 1'b0;

      nw = (cache_sb.ways_r == 0) ? 1 : ((cache_sb.ways_r > MAX_WAYS) ? MAX_WAYS
                                                                     : cache_sb.ways_r);
      pool_n = (nw + 2 > POOL_MAX) ? POOL_MAX : nw + 2;
      foreach (tag_pool[i])
        tag_pool[i] = $urandom_range(0, 1) ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_access());
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d accesses over %0d cache geometries and four idle patterns;",
             words_sent, PHASES + 1);
    $display("%0d hit and %0d evicting result words checked.",
             cache_sb.hits_seen, cache_sb.evicts_seen);
    if (cache_sb.errors == 0 && cache_sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
